/* src/des_pkg.sv */
`default_nettype none
package des_pkg;

  // Field and datapath widths fixed by the block's interface.
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned SPEED_W  = 24;
  localparam int unsigned TPR_W    = 16;
  localparam int unsigned WEIGHT_W = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Shared multiplier: 32 x 16 operands, 48-bit product and accumulator.
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [MUL_B_W-1:0]  RPM_SCALE    = 16'd60000;
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL  = 9'd256;
  localparam int unsigned         WEIGHT_SHIFT = 8;
  localparam logic [TPR_W-1:0]    TPR_RESET    = 16'd40;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 9'd230;

  localparam logic [CFG_IDX_W-1:0] CFG_TPR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LEFT   = 2'd0,
    KIND_RIGHT  = 2'd1,
    KIND_PERIOD = 2'd2
  } des_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_DEN,
    ST_MUL_NL,
    ST_DIV_L_START,
    ST_DIV_L_WAIT,
    ST_SM_L_A,
    ST_SM_L_B,
    ST_MUL_NR,
    ST_DIV_R_START,
    ST_DIV_R_WAIT,
    ST_SM_R_A,
    ST_SM_R_B,
    ST_SM_R_C,
    ST_DONE
  } des_state_e;

  typedef struct packed {
    logic en;
    logic accumulate;
  } des_mac_ctrl_t;

endpackage
`default_nettype wire

/* src/des_if.sv */
`default_nettype none
interface des_in_if;
  logic                         valid;
  logic                         ready;
  logic [des_pkg::KIND_W-1:0]   kind;
  logic [des_pkg::TIME_W-1:0]   timestamp_ms;

  modport source (output valid, output kind, output timestamp_ms, input ready);
  modport sink (input valid, input kind, input timestamp_ms, output ready);
endinterface

interface des_out_if;
  logic                          valid;
  logic                          ready;
  logic [des_pkg::SPEED_W-1:0]   speed_left;
  logic [des_pkg::SPEED_W-1:0]   speed_right;
  logic [des_pkg::COUNT_W-1:0]   count_left;
  logic [des_pkg::COUNT_W-1:0]   count_right;
  logic                          zero_interval;

  modport source (output valid, output speed_left, output speed_right,
                  output count_left, output count_right, output zero_interval,
                  input ready);
  modport sink (input valid, input speed_left, input speed_right,
                input count_left, input count_right, input zero_interval,
                output ready);
endinterface

interface des_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [des_pkg::CFG_IDX_W-1:0]   index;
  logic [des_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/des_mac.sv */
`default_nettype none
// Shared multiply-accumulate unit with a registered result.
module des_mac (
  input  wire                          clk_i,
  input  wire des_pkg::des_mac_ctrl_t  ctrl_i,
  input  wire [des_pkg::MUL_A_W-1:0]   a_i,
  input  wire [des_pkg::MUL_B_W-1:0]   b_i,
  output logic [des_pkg::PROD_W-1:0]   acc_o
);

  logic [des_pkg::PROD_W-1:0] prod;
  logic [des_pkg::PROD_W-1:0] acc_d, acc_q;

  assign prod = des_pkg::PROD_W'(a_i) * des_pkg::PROD_W'(b_i);

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.en) begin
      acc_d = ctrl_i.accumulate ? acc_q + prod : prod;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule
`default_nettype wire

/* src/des_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle. Returns
// min(floor(num * 2^FRAC_BITS / den), 2^SPEED_W - 1) for a nonzero den.
module des_div #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  input  wire [des_pkg::PROD_W-1:0]    num_i,
  input  wire [des_pkg::PROD_W-1:0]    den_i,
  output logic                         done_o,
  output logic [des_pkg::SPEED_W-1:0]  quot_o
);

  localparam int unsigned NW    = des_pkg::PROD_W + FRAC_BITS;
  localparam int unsigned HW    = NW - des_pkg::SPEED_W;
  localparam int unsigned CNT_W = $clog2(des_pkg::SPEED_W + 1);
  localparam int unsigned RW    = des_pkg::PROD_W;
  localparam int unsigned QW    = des_pkg::SPEED_W;

  logic [NW-1:0]    n_full;
  logic [HW-1:0]    n_hi;
  logic [RW-1:0]    rem_q, den_q;
  logic [QW-1:0]    lo_q, q_q;
  logic             sat_q;
  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RW:0]      rem_sh;
  logic [RW+1:0]    diff;
  logic             fits;

  assign n_full = NW'(num_i) << FRAC_BITS;
  assign n_hi   = n_full[NW-1:QW];

  // The quotient overflows exactly when the upper part already holds den.
  assign rem_sh = {rem_q, lo_q[QW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
  assign fits   = ~diff[RW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RW'(n_hi);
      lo_q  <= n_full[QW-1:0];
      den_q <= den_i;
      sat_q <= RW'(n_hi) >= den_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[RW-1:0] : rem_sh[RW-1:0];
      lo_q  <= lo_q << 1;
      q_q   <= {q_q[QW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = sat_q ? {QW{1'b1}} : q_q;

endmodule
`default_nettype wire

/* src/dual_encoder_speed_estimator_core.sv */
`default_nettype none
// Dual wheel encoder speed estimator.
//
// Input channel in_i carries one event per beat: a left tick, a right tick or
// a period end with a millisecond timestamp. A tick beat bumps that wheel's
// counter and needs no further step. A period-end beat produces one result beat
// on out_o: both smoothed rpm values (16.8 fixed point, saturated) and both
// captured tick counts, plus a flag when no time elapsed (speeds then held).
// Kind 3 beats are dropped.
// A period end with nonzero elapsed time runs a sequence of steps: one shared
// 32x16 multiply-accumulate unit forms the denominator, the scaled tick counts
// and the filter sums, and one restoring divider divides for each wheel in turn.
// A zero interval goes straight to the final step. in_i.ready is low while a
// period end is in work, so the next beat is taken only once the final step
// has moved its result into the output register.
// cfg_i writes the encoder count per wheel turn (index 0) and smoothing_weight
// (index 1); it is always ready and should be used only while the block is idle.
// After reset the counters, timestamps and speeds are zero and the registers
// hold 40 and 230. A result waits in the output register while out_o.ready is
// low; ticks are still accepted then, and the next period end finishes its
// arithmetic and waits for the output register to free up.
module dual_encoder_speed_estimator_core #(
  parameter int unsigned SPEED_FRAC_BITS = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  des_in_if.sink     in_i,
  des_out_if.source  out_o,
  des_cfg_if.sink    cfg_i
);

  localparam int unsigned CW = des_pkg::COUNT_W;
  localparam int unsigned SW = des_pkg::SPEED_W;
  localparam int unsigned AW = des_pkg::MUL_A_W;
  localparam int unsigned BW = des_pkg::MUL_B_W;
  localparam int unsigned PW = des_pkg::PROD_W;

  des_pkg::des_state_e state_q, state_d;

  // Configuration registers.
  logic [des_pkg::TPR_W-1:0]    tpr_q;
  logic [des_pkg::WEIGHT_W-1:0] weight_q;

  // Architectural state.
  logic [CW-1:0] left_ticks_q, right_ticks_q;
  logic [CW-1:0] left_prev_q, right_prev_q;
  logic [des_pkg::TIME_W-1:0] prev_time_q;
  logic [SW-1:0] filt_l_q, filt_r_q;

  // Operands captured when a period end is accepted, and the computed denominator.
  logic [des_pkg::TIME_W-1:0]   elapsed_q;
  logic [CW-1:0]                dl_q, dr_q;
  logic [des_pkg::TPR_W-1:0]    tpr_eff_q;
  logic [des_pkg::WEIGHT_W-1:0] w_eff_q;
  logic                         zero_q;
  logic [PW-1:0]                den_q;

  // Output register.
  logic          out_valid_q;
  logic [SW-1:0] out_speed_l_q, out_speed_r_q;
  logic [CW-1:0] out_count_l_q, out_count_r_q;
  logic          out_zero_q;

  logic [des_pkg::TIME_W-1:0] elapsed_now;
  logic in_fire, period_fire, cfg_fire;

  // Sequencer outputs.
  des_pkg::des_mac_ctrl_t mac_ctrl;
  logic [AW-1:0] mac_a;
  logic [BW-1:0] mac_b;
  logic [PW-1:0] mac_acc;
  logic          div_start, div_done;
  logic [SW-1:0] div_quot;
  logic          den_we, filt_l_we, filt_r_we, out_load, out_free;

  assign in_fire     = in_i.valid && in_i.ready;
  assign period_fire = in_fire && (in_i.kind == des_pkg::KIND_PERIOD);
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign elapsed_now = in_i.timestamp_ms - prev_time_q;
  assign out_free    = !out_valid_q || out_o.ready;

  assign cfg_i.ready = 1'b1;

  des_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (mac_acc)
  );

  des_div #(
    .FRAC_BITS (SPEED_FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mac_acc),
    .den_i   (den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      des_pkg::ST_IDLE: begin
        if (period_fire) begin
          state_d = (elapsed_now == '0) ? des_pkg::ST_DONE : des_pkg::ST_MUL_DEN;
        end
      end
      des_pkg::ST_MUL_DEN:     state_d = des_pkg::ST_MUL_NL;
      des_pkg::ST_MUL_NL:      state_d = des_pkg::ST_DIV_L_START;
      des_pkg::ST_DIV_L_START: state_d = des_pkg::ST_DIV_L_WAIT;
      des_pkg::ST_DIV_L_WAIT: begin
        if (div_done) begin
          state_d = des_pkg::ST_SM_L_A;
        end
      end
      des_pkg::ST_SM_L_A:      state_d = des_pkg::ST_SM_L_B;
      des_pkg::ST_SM_L_B:      state_d = des_pkg::ST_MUL_NR;
      des_pkg::ST_MUL_NR:      state_d = des_pkg::ST_DIV_R_START;
      des_pkg::ST_DIV_R_START: state_d = des_pkg::ST_DIV_R_WAIT;
      des_pkg::ST_DIV_R_WAIT: begin
        if (div_done) begin
          state_d = des_pkg::ST_SM_R_A;
        end
      end
      des_pkg::ST_SM_R_A:      state_d = des_pkg::ST_SM_R_B;
      des_pkg::ST_SM_R_B:      state_d = des_pkg::ST_SM_R_C;
      des_pkg::ST_SM_R_C:      state_d = des_pkg::ST_DONE;
      des_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = des_pkg::ST_IDLE;
        end
      end
      default:                 state_d = des_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: which operands go to the shared units in each step.
  always_comb begin
    in_i.ready          = 1'b0;
    mac_ctrl.en         = 1'b0;
    mac_ctrl.accumulate = 1'b0;
    mac_a               = '0;
    mac_b               = '0;
    div_start           = 1'b0;
    den_we              = 1'b0;
    filt_l_we           = 1'b0;
    filt_r_we           = 1'b0;
    out_load            = 1'b0;
    case (state_q)
      des_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
      end
      des_pkg::ST_MUL_DEN: begin
        // Denominator: ticks per revolution times elapsed milliseconds.
        mac_ctrl.en = 1'b1;
        mac_a       = AW'(elapsed_q);
        mac_b       = BW'(tpr_eff_q);
      end
      des_pkg::ST_MUL_NL: begin
        den_we      = 1'b1;
        mac_ctrl.en = 1'b1;
        mac_a       = AW'(dl_q);
        mac_b       = des_pkg::RPM_SCALE;
      end
      des_pkg::ST_DIV_L_START, des_pkg::ST_DIV_R_START: begin
        div_start = 1'b1;
      end
      des_pkg::ST_SM_L_A: begin
        mac_ctrl.en = 1'b1;
        mac_a       = AW'(filt_l_q);
        mac_b       = BW'(w_eff_q);
      end
      des_pkg::ST_SM_L_B, des_pkg::ST_SM_R_B: begin
        mac_ctrl.en         = 1'b1;
        mac_ctrl.accumulate = 1'b1;
        mac_a               = AW'(div_quot);
        mac_b               = BW'(des_pkg::WEIGHT_FULL - w_eff_q);
      end
      des_pkg::ST_MUL_NR: begin
        filt_l_we   = 1'b1;
        mac_ctrl.en = 1'b1;
        mac_a       = AW'(dr_q);
        mac_b       = des_pkg::RPM_SCALE;
      end
      des_pkg::ST_SM_R_A: begin
        mac_ctrl.en = 1'b1;
        mac_a       = AW'(filt_r_q);
        mac_b       = BW'(w_eff_q);
      end
      des_pkg::ST_SM_R_C: begin
        filt_r_we = 1'b1;
      end
      des_pkg::ST_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= des_pkg::ST_IDLE;
      tpr_q         <= des_pkg::TPR_RESET;
      weight_q      <= des_pkg::WEIGHT_RESET;
      left_ticks_q  <= '0;
      right_ticks_q <= '0;
      left_prev_q   <= '0;
      right_prev_q  <= '0;
      prev_time_q   <= '0;
      filt_l_q      <= '0;
      filt_r_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_fire) begin
        if (cfg_i.index == des_pkg::CFG_TPR) begin
          tpr_q <= cfg_i.data[des_pkg::TPR_W-1:0];
        end else if (cfg_i.index == des_pkg::CFG_WEIGHT) begin
          weight_q <= cfg_i.data[des_pkg::WEIGHT_W-1:0];
        end
      end

      if (in_fire && (in_i.kind == des_pkg::KIND_LEFT)) begin
        left_ticks_q <= left_ticks_q + 1'b1;
      end
      if (in_fire && (in_i.kind == des_pkg::KIND_RIGHT)) begin
        right_ticks_q <= right_ticks_q + 1'b1;
      end

      // The period's reference points move at accept, also on a zero interval.
      if (period_fire) begin
        prev_time_q  <= in_i.timestamp_ms;
        left_prev_q  <= left_ticks_q;
        right_prev_q <= right_ticks_q;
      end

      if (filt_l_we) begin
        filt_l_q <= mac_acc[des_pkg::WEIGHT_SHIFT +: SW];
      end
      if (filt_r_we) begin
        filt_r_q <= mac_acc[des_pkg::WEIGHT_SHIFT +: SW];
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (period_fire) begin
      elapsed_q <= elapsed_now;
      dl_q      <= left_ticks_q - left_prev_q;
      dr_q      <= right_ticks_q - right_prev_q;
      tpr_eff_q <= (tpr_q == '0) ? des_pkg::TPR_W'(1) : tpr_q;
      w_eff_q   <= (weight_q > des_pkg::WEIGHT_FULL) ? des_pkg::WEIGHT_FULL : weight_q;
      zero_q    <= (elapsed_now == '0);
    end
    if (den_we) begin
      den_q <= mac_acc;
    end
    if (out_load) begin
      out_speed_l_q <= filt_l_q;
      out_speed_r_q <= filt_r_q;
      out_count_l_q <= left_ticks_q;
      out_count_r_q <= right_ticks_q;
      out_zero_q    <= zero_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.speed_left    = out_speed_l_q;
  assign out_o.speed_right   = out_speed_r_q;
  assign out_o.count_left    = out_count_l_q;
  assign out_o.count_right   = out_count_r_q;
  assign out_o.zero_interval = out_zero_q;

  // The divider reports completion only while the sequencer waits for it.
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == des_pkg::ST_DIV_L_WAIT || state_q == des_pkg::ST_DIV_R_WAIT))
    else $error("divider done outside a divide wait step");

  // A period end with elapsed time starts the arithmetic in the next cycle.
  a_period_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (period_fire && elapsed_now != '0) |=> (state_q == des_pkg::ST_MUL_DEN))
    else $error("period end did not start the speed computation");

  // A new result appears only from the final step.
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == des_pkg::ST_DONE))
    else $error("result loaded outside the final step");

  // A left tick beat bumps the left counter by exactly one.
  a_left_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.kind == des_pkg::KIND_LEFT)
      |=> (left_ticks_q == $past(left_ticks_q) + 1'b1))
    else $error("left tick counter did not advance");

endmodule
`default_nettype wire
